FILE: hdl/rrfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_pkg: shared types and constants of the reply frame parser
// Result kinds, character codes and the record that travels from the
// classifying front end through the queue to the output sequencer.
// ----------------------------------------------------------------------------
package rrfp_pkg;

	// result kinds as seen on out_kind
	typedef enum logic [1:0] {
		KIND_MSG     = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	// character codes
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// prefix lengths of "+OK" and "-ERR"
	localparam logic [2:0] OK_LEN  = 3'd3;
	localparam logic [2:0] ERR_LEN = 3'd4;

	// record queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	// width of the reported length
	localparam int OUT_LEN_BITS = 32;

	// one queued record: an optional flushed CR beat ahead of the main beat
	typedef struct packed {
		logic                    has_cr;
		kind_t                   kind;
		logic [7:0]              data;
		logic                    frame_ok;
		logic                    success;
		logic [OUT_LEN_BITS-1:0] length;
	} rec_t;

	// expected prefix character at a given position
	function automatic logic [7:0] prefix_char(input logic succ, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (succ) begin
			case (idx)
				3'd1: ch = CH_O;
				3'd2: ch = CH_K;
				default: ch = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd1: ch = CH_E;
				3'd2: ch = CH_R;
				3'd3: ch = CH_R;
				default: ch = 8'h00;
			endcase
		end
		return ch;
	endfunction

endpackage

FILE: hdl/rrfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_front: frame classifier
// Runs the parse state per accepted byte and pushes one record per byte that
// yields results: message bytes, data bytes or the end of frame verdict.
// ----------------------------------------------------------------------------
module rrfp_front #(
	parameter int LEN_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push_valid,
	output rrfp_pkg::rec_t   push_rec,
	input  logic             push_ready
);

	typedef enum logic [3:0] {
		PH_PREFIX,
		PH_AFTER_PREFIX,
		PH_STATUS_LF,
		PH_MESSAGE,
		PH_DOLLAR,
		PH_LEN_FIRST,
		PH_LEN_MORE,
		PH_LEN_LF,
		PH_DATA,
		PH_END_LF,
		PH_FAULT
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [2:0]          pidx_q, pidx_d;
	logic                succ_q, succ_d;
	logic                pend_cr_q, pend_cr_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [LEN_BITS-1:0] remain_q, remain_d;

	logic                fire;
	logic                emit;
	rrfp_pkg::rec_t      rec;
	logic                is_digit;
	logic [3:0]          digit;
	logic [LEN_BITS+3:0] len_x10;
	logic                len_ovf;
	logic [2:0]          plen;
	logic                verdict_ok;
	logic [LEN_BITS+rrfp_pkg::OUT_LEN_BITS-1:0] len_ext;

	assign fire     = in_valid && push_ready;
	assign in_ready = push_ready;

	// decimal accumulate with overflow check past LEN_BITS
	assign is_digit = (in_byte >= rrfp_pkg::CH_ZERO) && (in_byte <= rrfp_pkg::CH_NINE);
	assign digit    = 4'(in_byte - rrfp_pkg::CH_ZERO);
	assign len_x10  = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
		+ (LEN_BITS+4)'(digit);
	assign len_ovf  = |len_x10[LEN_BITS+3:LEN_BITS];

	assign plen       = succ_q ? rrfp_pkg::OK_LEN : rrfp_pkg::ERR_LEN;
	assign verdict_ok = (phase_q == PH_END_LF) && (in_byte == rrfp_pkg::CH_LF);
	assign len_ext    = {{rrfp_pkg::OUT_LEN_BITS{1'b0}}, len_q};

	// next state and record contents
	always_comb begin
		phase_d   = phase_q;
		pidx_d    = pidx_q;
		succ_d    = succ_q;
		pend_cr_d = pend_cr_q;
		len_d     = len_q;
		remain_d  = remain_q;
		emit      = 1'b0;
		rec       = '0;
		rec.kind  = rrfp_pkg::KIND_MSG;
		rec.data  = in_byte;

		if (in_last) begin
			emit          = 1'b1;
			rec.kind      = rrfp_pkg::KIND_VERDICT;
			rec.data      = 8'h00;
			rec.frame_ok  = verdict_ok;
			rec.success   = verdict_ok && succ_q;
			rec.length    = verdict_ok ? len_ext[rrfp_pkg::OUT_LEN_BITS-1:0] : '0;
			phase_d       = PH_PREFIX;
			pidx_d        = 3'd0;
			succ_d        = 1'b0;
			pend_cr_d     = 1'b0;
			len_d         = '0;
			remain_d      = '0;
		end else begin
			case (phase_q)
				PH_PREFIX: begin
					if (pidx_q == 3'd0) begin
						if (in_byte == rrfp_pkg::CH_PLUS) begin
							succ_d = 1'b1;
							pidx_d = 3'd1;
						end else if (in_byte == rrfp_pkg::CH_MINUS) begin
							succ_d = 1'b0;
							pidx_d = 3'd1;
						end else begin
							phase_d = PH_FAULT;
						end
					end else if ((pidx_q < plen)
						&& (in_byte == rrfp_pkg::prefix_char(succ_q, pidx_q))) begin
						pidx_d = pidx_q + 3'd1;
						if (pidx_q + 3'd1 == plen)
							phase_d = PH_AFTER_PREFIX;
					end else begin
						phase_d = PH_FAULT;
					end
				end
				PH_AFTER_PREFIX: begin
					if (in_byte == rrfp_pkg::CH_SPACE)
						phase_d = PH_MESSAGE;
					else if (in_byte == rrfp_pkg::CH_CR)
						phase_d = PH_STATUS_LF;
					else
						phase_d = PH_FAULT;
				end
				PH_STATUS_LF: begin
					phase_d = (in_byte == rrfp_pkg::CH_LF) ? PH_DOLLAR : PH_FAULT;
				end
				PH_MESSAGE: begin
					if (pend_cr_q) begin
						if (in_byte == rrfp_pkg::CH_LF) begin
							pend_cr_d = 1'b0;
							phase_d   = PH_DOLLAR;
						end else if (in_byte == rrfp_pkg::CH_CR) begin
							// held cr goes out, the new one is held
							emit = 1'b1;
						end else begin
							// held cr goes out ahead of this byte
							emit       = 1'b1;
							rec.has_cr = 1'b1;
							pend_cr_d  = 1'b0;
						end
					end else if (in_byte == rrfp_pkg::CH_CR) begin
						pend_cr_d = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
				PH_DOLLAR: begin
					if (in_byte == rrfp_pkg::CH_DOLLAR) begin
						phase_d = PH_LEN_FIRST;
						len_d   = '0;
					end else begin
						phase_d = PH_FAULT;
					end
				end
				PH_LEN_FIRST, PH_LEN_MORE: begin
					if (is_digit) begin
						if (len_ovf) begin
							phase_d = PH_FAULT;
						end else begin
							len_d   = len_x10[LEN_BITS-1:0];
							phase_d = PH_LEN_MORE;
						end
					end else if ((in_byte == rrfp_pkg::CH_CR) && (phase_q == PH_LEN_MORE)) begin
						phase_d = PH_LEN_LF;
					end else begin
						phase_d = PH_FAULT;
					end
				end
				PH_LEN_LF: begin
					if (in_byte == rrfp_pkg::CH_LF) begin
						phase_d  = PH_DATA;
						remain_d = len_q;
					end else begin
						phase_d = PH_FAULT;
					end
				end
				PH_DATA: begin
					if (remain_q != '0) begin
						emit     = 1'b1;
						rec.kind = rrfp_pkg::KIND_DATA;
						remain_d = remain_q - LEN_BITS'(1);
					end else if (in_byte == rrfp_pkg::CH_CR) begin
						phase_d = PH_END_LF;
					end else begin
						phase_d = PH_FAULT;
					end
				end
				default: begin
					phase_d = PH_FAULT;
				end
			endcase
			if (phase_d == PH_FAULT)
				pend_cr_d = 1'b0;
		end
	end

	assign push_valid = fire && emit;
	assign push_rec   = rec;

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			pidx_q    <= 3'd0;
			succ_q    <= 1'b0;
			pend_cr_q <= 1'b0;
			len_q     <= '0;
			remain_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			pidx_q    <= pidx_d;
			succ_q    <= succ_d;
			pend_cr_q <= pend_cr_d;
			len_q     <= len_d;
			remain_q  <= remain_d;
		end
	end

endmodule

FILE: hdl/rrfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_queue: record queue
// Small first-in first-out store between the classifier and the output
// sequencer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rrfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  rrfp_pkg::rec_t push_rec,
	output logic           push_ready,
	output logic           pop_valid,
	output rrfp_pkg::rec_t pop_rec,
	input  logic           pop_ready
);

	rrfp_pkg::rec_t                  mem_q [rrfp_pkg::QUEUE_DEPTH];
	logic [rrfp_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [rrfp_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [rrfp_pkg::QCNT_BITS-1:0]  count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != rrfp_pkg::QCNT_BITS'(rrfp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_rec    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + rrfp_pkg::QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + rrfp_pkg::QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + rrfp_pkg::QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - rrfp_pkg::QCNT_BITS'(1);
		end
	end

endmodule

FILE: hdl/rrfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfp_back: output sequencer
// Turns each queued record into one or two result beats (a flushed CR ahead
// of the byte that follows it) and holds them in the output register.
// ----------------------------------------------------------------------------
module rrfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  rrfp_pkg::rec_t pop_rec,
	output logic           pop_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic           frame_valid,
	output logic           status_success,
	output logic [31:0]    data_length,
	output logic           run_last
);

	logic                 out_valid_q;
	rrfp_pkg::kind_t      kind_q;
	logic [7:0]           byte_q;
	logic                 ok_q;
	logic                 succ_q;
	logic [31:0]          len_q;
	logic                 cr_done_q;
	logic                 load;
	logic                 split;

	// output register free or being emptied this cycle
	assign load      = !out_valid_q || out_ready;
	assign split     = pop_rec.has_cr && !cr_done_q;
	assign pop_ready = load && !split;

	// control: beat valid and cr half of a split record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cr_done_q   <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid)
				cr_done_q <= split;
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			if (split) begin
				kind_q <= rrfp_pkg::KIND_MSG;
				byte_q <= rrfp_pkg::CH_CR;
				ok_q   <= 1'b0;
				succ_q <= 1'b0;
				len_q  <= '0;
			end else begin
				kind_q <= pop_rec.kind;
				byte_q <= pop_rec.data;
				ok_q   <= pop_rec.frame_ok;
				succ_q <= pop_rec.success;
				len_q  <= pop_rec.length;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = kind_q;
	assign out_byte       = byte_q;
	assign frame_valid    = ok_q;
	assign status_success = succ_q;
	assign data_length    = len_q;
	assign run_last       = (kind_q == rrfp_pkg::KIND_VERDICT);

endmodule

FILE: hdl/resp_reply_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_reply_frame_parser: reply frame parser top level
// Byte-wide parser of "+OK"/"-ERR" reply frames carrying a length-prefixed
// bulk payload; streams message and data bytes and ends each frame with a
// verdict beat.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle (in_last on the final byte)
// while the queue has room, and emits one result beat per cycle while
// out_ready is high. Most bytes give zero or one beat; a message byte that
// follows a held CR gives two (the CR, then the byte), so the sustained
// input rate is one byte per cycle except behind such pairs. A byte is
// classified and written to a four-record queue at the edge that accepts
// it, and the output register loads from the queue whenever it is free or
// being emptied. The queue lets input keep flowing while the output stalls,
// until it holds four records. A length that does not fit in LEN_BITS
// bits is a protocol error; data_length reports the low 32 bits of the
// length.
module resp_reply_frame_parser #(
	parameter int LEN_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        frame_valid,
	output logic        status_success,
	output logic [31:0] data_length,
	output logic        run_last
);

	logic           push_valid;
	logic           push_ready;
	rrfp_pkg::rec_t push_rec;
	logic           pop_valid;
	logic           pop_ready;
	rrfp_pkg::rec_t pop_rec;

	// classifier
	rrfp_front #(
		.LEN_BITS(LEN_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push_valid(push_valid),
		.push_rec  (push_rec),
		.push_ready(push_ready)
	);

	// record queue
	rrfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_rec  (push_rec),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop_ready (pop_ready)
	);

	// output sequencer
	rrfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_rec       (pop_rec),
		.pop_ready     (pop_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind),
		.out_byte      (out_byte),
		.frame_valid   (frame_valid),
		.status_success(status_success),
		.data_length   (data_length),
		.run_last      (run_last)
	);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the reply frame parser
// Sends reply frames byte by byte, predicts the message, data and verdict
// beats in a local parse model and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 160;
	localparam logic [63:0] LEN_MAX = 64'h0000_0000_FFFF_FFFF;

	// parse states of the local model
	typedef enum logic [3:0] {
		ST_PREFIX, ST_AFTER_PREFIX, ST_STATUS_LF, ST_MESSAGE, ST_DOLLAR,
		ST_LEN_FIRST, ST_LEN_MORE, ST_LEN_LF, ST_DATA, ST_END_LF, ST_FAULT
	} parse_state_t;

	typedef struct packed {
		rrfp_pkg::kind_t kind;
		logic [7:0]      data;
		logic            ok;
		logic            succ;
		logic [31:0]     len;
		logic            last;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        frame_valid;
	logic        status_success;
	logic [31:0] data_length;
	logic        run_last;

	// local parse model state
	parse_state_t pstate;
	logic [2:0]   matched;
	logic         plus_seen;
	logic         cr_held;
	logic [63:0]  len_acc;
	logic [63:0]  data_left;

	beat_t      parsed_beats[$];
	logic [7:0] frame_q[$];

	bit idle_on;
	bit stall_on;
	bit hold_req;
	int bytes_sent;
	int frames_sent;
	int beats_checked;
	int verdicts_seen;
	int mismatches;
	int cycle_count;

	resp_reply_frame_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.in_last        (in_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.frame_valid    (frame_valid),
		.status_success (status_success),
		.data_length    (data_length),
		.run_last       (run_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				parsed_beats.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model

	task automatic restart_parse();
		pstate    = ST_PREFIX;
		matched   = 3'd0;
		plus_seen = 1'b0;
		cr_held   = 1'b0;
		len_acc   = 64'd0;
		data_left = 64'd0;
	endtask

	task automatic push_beat(input rrfp_pkg::kind_t k, input logic [7:0] b, input logic ok,
			input logic succ, input logic [31:0] len, input logic fin);
		beat_t bt;
		bt.kind = k;
		bt.data = b;
		bt.ok   = ok;
		bt.succ = succ;
		bt.len  = len;
		bt.last = fin;
		parsed_beats.push_back(bt);
	endtask

	// advance the model by one accepted byte, queueing the beats it causes
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		logic        ok;
		logic [63:0] digit;
		logic [2:0]  plen;
		logic [7:0]  want_ch;
		logic        ended_msg;
		if (fin) begin
			// final byte: verdict only, a held cr is dropped
			ok = (pstate == ST_END_LF) && (b == rrfp_pkg::CH_LF);
			push_beat(rrfp_pkg::KIND_VERDICT, 8'h00, ok, ok & plus_seen,
				ok ? len_acc[31:0] : 32'd0, 1'b1);
			restart_parse();
		end else begin
			case (pstate)
				ST_PREFIX: begin
					if (matched == 3'd0) begin
						if (b == rrfp_pkg::CH_PLUS) begin
							plus_seen = 1'b1;
							matched   = 3'd1;
						end else if (b == rrfp_pkg::CH_MINUS) begin
							plus_seen = 1'b0;
							matched   = 3'd1;
						end else begin
							pstate = ST_FAULT;
						end
					end else begin
						plen = plus_seen ? rrfp_pkg::OK_LEN : rrfp_pkg::ERR_LEN;
						if (plus_seen)
							want_ch = (matched == 3'd1) ? rrfp_pkg::CH_O : rrfp_pkg::CH_K;
						else
							want_ch = (matched == 3'd1) ? rrfp_pkg::CH_E : rrfp_pkg::CH_R;
						if (matched < plen && b == want_ch) begin
							matched++;
							if (matched == plen)
								pstate = ST_AFTER_PREFIX;
						end else begin
							pstate = ST_FAULT;
						end
					end
				end
				ST_AFTER_PREFIX: begin
					if (b == rrfp_pkg::CH_SPACE)
						pstate = ST_MESSAGE;
					else if (b == rrfp_pkg::CH_CR)
						pstate = ST_STATUS_LF;
					else
						pstate = ST_FAULT;
				end
				ST_STATUS_LF: pstate = (b == rrfp_pkg::CH_LF) ? ST_DOLLAR : ST_FAULT;
				ST_MESSAGE: begin
					// a held cr either closes the line or is flushed as message
					ended_msg = 1'b0;
					if (cr_held) begin
						cr_held = 1'b0;
						if (b == rrfp_pkg::CH_LF) begin
							pstate    = ST_DOLLAR;
							ended_msg = 1'b1;
						end else begin
							push_beat(rrfp_pkg::KIND_MSG, rrfp_pkg::CH_CR, 1'b0, 1'b0,
								32'd0, 1'b0);
						end
					end
					if (!ended_msg) begin
						if (b == rrfp_pkg::CH_CR)
							cr_held = 1'b1;
						else
							push_beat(rrfp_pkg::KIND_MSG, b, 1'b0, 1'b0, 32'd0, 1'b0);
					end
				end
				ST_DOLLAR: begin
					if (b == rrfp_pkg::CH_DOLLAR) begin
						pstate  = ST_LEN_FIRST;
						len_acc = 64'd0;
					end else begin
						pstate = ST_FAULT;
					end
				end
				ST_LEN_FIRST, ST_LEN_MORE: begin
					if (b >= rrfp_pkg::CH_ZERO && b <= rrfp_pkg::CH_NINE) begin
						digit = 64'(b - rrfp_pkg::CH_ZERO);
						if (len_acc > (LEN_MAX - digit) / 64'd10) begin
							pstate = ST_FAULT;
						end else begin
							len_acc = len_acc * 64'd10 + digit;
							pstate  = ST_LEN_MORE;
						end
					end else if (b == rrfp_pkg::CH_CR && pstate == ST_LEN_MORE) begin
						pstate = ST_LEN_LF;
					end else begin
						pstate = ST_FAULT;
					end
				end
				ST_LEN_LF: begin
					if (b == rrfp_pkg::CH_LF) begin
						pstate    = ST_DATA;
						data_left = len_acc;
					end else begin
						pstate = ST_FAULT;
					end
				end
				ST_DATA: begin
					if (data_left != 64'd0) begin
						push_beat(rrfp_pkg::KIND_DATA, b, 1'b0, 1'b0, 32'd0, 1'b0);
						data_left--;
					end else if (b == rrfp_pkg::CH_CR) begin
						pstate = ST_END_LF;
					end else begin
						pstate = ST_FAULT;
					end
				end
				// a non-final byte after the closing cr, and the fault state itself
				default: pstate = ST_FAULT;
			endcase
			if (pstate == ST_FAULT)
				cr_held = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- checker

	task automatic report(input string what, input logic [31:0] exp, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp, got);
	endtask

	// compare each accepted output beat with the oldest prediction
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (parsed_beats.size() == 0) begin
				report("unexpected beat, byte", 32'd0, {24'd0, out_byte});
			end else begin
				want = parsed_beats.pop_front();
				if (out_kind !== want.kind)
					report("out_kind", want.kind, out_kind);
				if (out_byte !== want.data)
					report("out_byte", want.data, out_byte);
				if (frame_valid !== want.ok)
					report("frame_valid", want.ok, frame_valid);
				if (status_success !== want.succ)
					report("status_success", want.succ, status_success);
				if (data_length !== want.len)
					report("data_length", want.len, data_length);
				if (run_last !== want.last)
					report("run_last", want.last, run_last);
				beats_checked++;
				if (want.last)
					verdicts_seen++;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offer one byte and wait for it to be accepted
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
	endtask

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_q.push_back(s[i]);
	endtask

	task automatic send_text(input string s);
		frame_q.delete();
		append_text(s);
		send_frame();
	endtask

	// well-formed layout with random message and data content
	task automatic build_frame(input logic succ, input int msg_len, input string len_txt,
			input int data_n);
		logic [7:0] c;
		logic [7:0] prev;
		frame_q.delete();
		if (succ)
			append_text("+OK");
		else
			append_text("-ERR");
		if (msg_len >= 0) begin
			frame_q.push_back(rrfp_pkg::CH_SPACE);
			prev = rrfp_pkg::CH_SPACE;
			for (int i = 0; i < msg_len; i++) begin
				c = ($urandom_range(0, 5) == 0) ? rrfp_pkg::CH_CR : 8'($urandom);
				// keep cr lf from closing the line early
				if (prev == rrfp_pkg::CH_CR && c == rrfp_pkg::CH_LF)
					c = 8'($urandom_range(11, 255));
				frame_q.push_back(c);
				prev = c;
			end
		end
		append_text("\015\n$");
		append_text(len_txt);
		append_text("\015\n");
		repeat (data_n) frame_q.push_back(8'($urandom));
		append_text("\015\n");
	endtask

	task automatic random_frame();
		int    msg_len;
		int    data_n;
		string txt;
		case ($urandom_range(0, 9))
			0, 1, 2: msg_len = -1;
			9:       msg_len = $urandom_range(13, 48);
			default: msg_len = $urandom_range(0, 12);
		endcase
		data_n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 16) : $urandom_range(17, 80);
		txt = $sformatf("%0d", data_n);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) txt = {"0", txt};
		build_frame($urandom_range(0, 1), msg_len, txt, data_n);
	endtask

	// break a frame in one random way
	task automatic damage_frame();
		int    pos;
		int    cut;
		int    msg_len;
		string txt;
		case ($urandom_range(0, 4))
			0: begin
				pos = $urandom_range(0, frame_q.size() - 1);
				frame_q[pos] = 8'($urandom);
			end
			1: begin
				cut = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > cut) void'(frame_q.pop_back());
			end
			2: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
			3: begin
				case ($urandom_range(0, 4))
					0:       txt = "4294967296";
					1:       txt = "18446744073709551616";
					2:       txt = "";
					3:       txt = "12x";
					default: txt = "4294967295";
				endcase
				msg_len = int'($urandom_range(0, 4)) - 1;
				build_frame($urandom_range(0, 1), msg_len, txt, $urandom_range(0, 4));
			end
			default: begin
				pos = $urandom_range(0, frame_q.size() - 1);
				frame_q.insert(pos, 8'($urandom));
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_well_formed();
		send_text("+OK\015\n$0\015\n\015\n");
		send_text("-ERR boom\015\n$3\015\nabc\015\n");
		send_text("+OK \015\n$1\015\nZ\015\n");
		// extreme byte values in message and data
		frame_q.delete();
		append_text("-ERR ");
		frame_q.push_back(8'h00);
		frame_q.push_back(8'hFF);
		append_text("\015\n$2\015\n");
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		append_text("\015\n");
		send_frame();
	endtask

	task automatic test_held_cr();
		send_text("+OK a\015b\015\015\n$0\015\n\015\n");
		send_text("-ERR x\015y");
		send_text("+OK \015\015\n$1\015\n\015\015\n");
	endtask

	task automatic test_prefix_faults();
		send_text("+OX\015\n$0\015\n\015\n");
		send_text("-ER\015\n$0\015\n\015\n");
		send_text("*OK\015\n");
		send_text("+OKx\015\n");
		send_text("+OK\015x$0\015\n\015\n");
		send_text("-ERRR\015\n");
		send_text("\n");
	endtask

	task automatic test_length_text();
		send_text("+OK\015\n$\015\n\015\n");
		send_text("+OK\015\n$1a\015\nx\015\n");
		send_text("-ERR\015\n$007\015\nabcdefg\015\n");
		send_text("+OK\015\n$4294967295\015\nab\015\n");
		send_text("+OK\015\n$4294967296\015\n\015\n");
	endtask

	task automatic test_frame_end();
		send_text("+OK\015\n$0\015\n\015\nX");
		send_text("+OK\015\n$0\015\n\015");
		send_text("+OK\015\n$3\015\nab\015\n");
		send_text("+OK\015\n$1\015\nab\015\n");
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		hold_req = 1'b1;
		build_frame(1'b1, 6, "40", 40);
		send_frame();
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int goal;
		int quiet_from;
		int sel;
		goal       = 1550;
		quiet_from = 1300;
		while (bytes_sent < goal) begin
			if (bytes_sent >= quiet_from) begin
				idle_on  = 1'b0;
				stall_on = 1'b0;
			end else begin
				idle_on  = ($urandom_range(0, 3) != 0);
				stall_on = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				// noise
				frame_q.delete();
				repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
			end else begin
				random_frame();
				if (sel >= 70)
					damage_frame();
			end
			send_frame();
		end
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		in_last  <= 1'b0;
		idle_on  = 1'b1;
		stall_on = 1'b1;
		hold_req = 1'b0;
		restart_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_well_formed();
		test_held_cr();
		test_prefix_faults();
		test_length_text();
		test_frame_end();
		test_backpressure();
		test_random_frames();

		in_valid <= 1'b0;
		while (parsed_beats.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("run: %0d frames, %0d bytes in, %0d beats checked, %0d verdicts",
			frames_sent, bytes_sent, beats_checked, verdicts_seen);
		$display("run: directed edge frames, one %0d-cycle output hold, %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: resp_reply_frame_parser.f
hdl/rrfp_pkg.sv
hdl/rrfp_front.sv
hdl/rrfp_queue.sv
hdl/rrfp_back.sv
hdl/resp_reply_frame_parser.sv
tb/sv/tb_top.sv
